FILE: src/fatlb_pkg.sv
// ----------------------------------------------------------------------------
// fatlb_pkg: shared types and constants of the translation cache
// Action codes, controller states, command and status bundles, port widths.
// ----------------------------------------------------------------------------
package fatlb_pkg;

	localparam int VA_W        = 48;
	localparam int PA_W        = 52;
	localparam int ACTION_W    = 2;
	localparam int S_TDATA_W   = 104;
	localparam int M_TDATA_W   = 56;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic CFG_WORD_CACHE_ENABLE = 1'b0;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_REFILL = 2'd1,
		ACT_FLUSH  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_ACT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic compare;
		logic read;
		logic touch;
		logic fill;
		logic flush;
		logic act_done;
		logic res_hit;
		logic load_out;
	} fatlb_cmd_t;

	typedef struct packed {
		action_t act;
		logic    hit;
		logic    upd;
		logic    out_free;
	} fatlb_stat_t;

endpackage

FILE: src/fully_assoc_tlb_lru_core.sv
// ----------------------------------------------------------------------------
// fully_assoc_tlb_lru_core: fully associative translation cache, LRU refill
// Caches virtual page to physical frame translations of pages of 2^PAGE_BITS bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat on s_*: s_tuser carries the action (lookup, refill, flush),
//   s_tdata the virtual address, the physical address and the recency flag.
//   Every input beat yields exactly one output beat on m_*: hit flag,
//   translated address (lookup hits only) and eviction flag.
//   An accepted item then passes these steps: parallel tag compare over
//   all entries, table update with frame RAM read, result load into the
//   output register. One item is in flight at a time and the controller
//   accepts only in its idle state, so a new item is taken only after the
//   last one has been loaded into the output register; the frame RAM read
//   follows the compare and the recency update needs the compare result.
//   The output register decouples the sides: the next beat is accepted
//   while a result waits; a stalled receiver holds the controller in its
//   result stage once the following item reaches it.
//   Reset empties the cache, clears all ranks and sets cache_enable to 1;
//   no clearing pass is needed. cache_enable lies at APB byte address 0.
// ----------------------------------------------------------------------------
module fully_assoc_tlb_lru_core #(
	parameter int ENTRIES   = 32,
	parameter int PAGE_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [fatlb_pkg::S_TDATA_W-1:0]     s_tdata,  // virt_addr, phys_addr, update_recency
	input  logic [fatlb_pkg::ACTION_W-1:0]      s_tuser,  // action
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fatlb_pkg::M_TDATA_W-1:0]     m_tdata,  // hit, trans_addr, evicted
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fatlb_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [fatlb_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [fatlb_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                pready
);

	import fatlb_pkg::*;

	logic        cache_enable_q;
	logic        sel_enable;
	fatlb_cmd_t  cmd;
	fatlb_stat_t stat;

	assign pready     = 1'b1;
	assign sel_enable = (paddr[CFG_ADDR_W-1:2] == CFG_WORD_CACHE_ENABLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_enable_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && sel_enable) begin
			cache_enable_q <= pwdata[0];
		end
	end

	assign prdata = sel_enable ? {{(CFG_DATA_W-1){1'b0}}, cache_enable_q} : '0;

	fatlb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.cache_enable (cache_enable_q),
		.stat         (stat),
		.cmd          (cmd)
	);

	fatlb_dp #(
		.ENTRIES   (ENTRIES),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: src/fatlb_ram.sv
// ----------------------------------------------------------------------------
// fatlb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fatlb_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/fatlb_ctrl.sv
// ----------------------------------------------------------------------------
// fatlb_ctrl: controller of the translation cache
// Sequences capture, tag compare, table update and result hand-off.
// ----------------------------------------------------------------------------
module fatlb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic                 cache_enable,
	input  fatlb_pkg::fatlb_stat_t stat,
	output fatlb_pkg::fatlb_cmd_t  cmd
);

	import fatlb_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   lookup_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		s_tready   = 1'b0;
		lookup_hit = (stat.act == ACT_LOOKUP) && cache_enable && stat.hit;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				state_d     = ST_ACT;
			end
			ST_ACT: begin
				cmd.read     = lookup_hit;
				cmd.touch    = lookup_hit && stat.upd;
				cmd.fill     = (stat.act == ACT_REFILL) && cache_enable && !stat.hit;
				cmd.flush    = (stat.act == ACT_FLUSH);
				cmd.res_hit  = ((stat.act == ACT_LOOKUP) || (stat.act == ACT_REFILL)) &&
				               cache_enable && stat.hit;
				cmd.act_done = 1'b1;
				state_d      = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: src/fatlb_dp.sv
// ----------------------------------------------------------------------------
// fatlb_dp: datapath of the translation cache
// Tag array with parallel compare, recency ranks, frame RAM, output register.
// ----------------------------------------------------------------------------
module fatlb_dp #(
	parameter int ENTRIES   = 32,
	parameter int PAGE_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [fatlb_pkg::ACTION_W-1:0]     s_tuser,
	input  logic [fatlb_pkg::S_TDATA_W-1:0]    s_tdata,
	input  fatlb_pkg::fatlb_cmd_t              cmd,
	output fatlb_pkg::fatlb_stat_t             stat,
	input  logic                               m_tready,
	output logic                               m_tvalid,
	output logic [fatlb_pkg::M_TDATA_W-1:0]    m_tdata
);

	import fatlb_pkg::*;

	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int TAG_W   = VA_W - PAGE_BITS;
	localparam int FRAME_W = PA_W - PAGE_BITS;

	action_t              act_q;
	logic [TAG_W-1:0]     vpn_q;
	logic [PAGE_BITS-1:0] off_q;
	logic [FRAME_W-1:0]   pfn_q;
	logic                 upd_q;

	logic [TAG_W-1:0]     tag_q  [ENTRIES];
	logic [IDX_W-1:0]     rank_q [ENTRIES];
	logic [CNT_W-1:0]     cnt_q;
	logic [ENTRIES-1:0]   match_s1;

	logic [ENTRIES-1:0]   victim_vec;
	logic [IDX_W-1:0]     hit_idx;
	logic [IDX_W-1:0]     hit_rank;
	logic [IDX_W-1:0]     victim_idx;
	logic [IDX_W-1:0]     slot_idx;
	logic [IDX_W-1:0]     tgt_idx;
	logic [IDX_W-1:0]     tgt_rank;
	logic [CNT_W-1:0]     top_rank;
	logic                 full;
	logic                 touch_en;
	logic                 append;

	logic [FRAME_W-1:0]   frame_rd;
	logic                 res_hit_q;
	logic                 res_evict_q;
	logic                 res_read_q;
	logic [PA_W-1:0]      trans;
	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= action_t'(s_tuser);
			vpn_q <= s_tdata[VA_W-1:PAGE_BITS];
			off_q <= s_tdata[PAGE_BITS-1:0];
			pfn_q <= s_tdata[VA_W+PA_W-1:VA_W+PAGE_BITS];
			upd_q <= s_tdata[VA_W+PA_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			for (int i = 0; i < ENTRIES; i++) begin
				match_s1[i] <= (CNT_W'(i) < cnt_q) && (tag_q[i] == vpn_q);
			end
		end
	end

	always_comb begin
		hit_idx    = '0;
		hit_rank   = '0;
		victim_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			victim_vec[i] = (CNT_W'(i) < cnt_q) && (rank_q[i] == '0);
			if (match_s1[i]) begin
				hit_idx  = hit_idx | IDX_W'(i);
				hit_rank = hit_rank | rank_q[i];
			end
			if (victim_vec[i]) begin
				victim_idx = victim_idx | IDX_W'(i);
			end
		end
	end

	assign full     = (cnt_q == CNT_W'(ENTRIES));
	assign slot_idx = full ? victim_idx : cnt_q[IDX_W-1:0];
	assign touch_en = cmd.touch || (cmd.fill && full);
	assign append   = cmd.fill && !full;
	assign tgt_idx  = cmd.fill ? victim_idx : hit_idx;
	assign tgt_rank = cmd.fill ? '0 : hit_rank;
	assign top_rank = cnt_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (cmd.flush) begin
				cnt_q <= '0;
			end else if (append) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			for (int i = 0; i < ENTRIES; i++) begin
				if (cmd.flush) begin
					rank_q[i] <= '0;
				end else if (touch_en) begin
					if (IDX_W'(i) == tgt_idx) begin
						rank_q[i] <= top_rank[IDX_W-1:0];
					end else if ((CNT_W'(i) < cnt_q) && (rank_q[i] > tgt_rank)) begin
						rank_q[i] <= rank_q[i] - IDX_W'(1);
					end
				end else if (append && (IDX_W'(i) == slot_idx)) begin
					rank_q[i] <= cnt_q[IDX_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (cmd.fill && (IDX_W'(i) == slot_idx)) begin
				tag_q[i] <= vpn_q;
			end
		end
	end

	fatlb_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (ENTRIES)
	) u_frame_ram (
		.clk   (clk),
		.we    (cmd.fill),
		.waddr (slot_idx),
		.wdata (pfn_q),
		.re    (cmd.read),
		.raddr (hit_idx),
		.rdata (frame_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.act_done) begin
			res_hit_q   <= cmd.res_hit;
			res_evict_q <= cmd.fill && full;
			res_read_q  <= cmd.read;
		end
	end

	assign trans = res_read_q ? {frame_rd, off_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= {{(M_TDATA_W-PA_W-2){1'b0}}, res_evict_q, trans, res_hit_q};
		end
	end

	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_data_q;
	assign stat.act      = act_q;
	assign stat.hit      = |match_s1;
	assign stat.upd      = upd_q;
	assign stat.out_free = !out_valid_q || m_tready;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond capacity");

	a_one_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fill && full) |-> $onehot(victim_vec))
		else $error("no unique least recently used entry");

	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.read || cmd.touch) |-> $onehot(match_s1))
		else $error("lookup hit on more than one entry");

	a_append_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		append |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("fill did not advance entry count");

endmodule

FILE: tb/tlb_translation_checker.sv
// ----------------------------------------------------------------------------
// tlb_translation_checker: result checker for the translation cache
// Watches the input, output and register ports of the cache. Keeps its own
// copy of the entries, ranks and enable bit, works out the result of every
// accepted input beat and compares each output beat field by field.
// ----------------------------------------------------------------------------
module tlb_translation_checker #(
	parameter int ENTRIES   = 32,
	parameter int PAGE_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [fatlb_pkg::S_TDATA_W-1:0]     s_tdata,  // virt_addr, phys_addr, update_recency
	input  logic [fatlb_pkg::ACTION_W-1:0]      s_tuser,  // action
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [fatlb_pkg::M_TDATA_W-1:0]     m_tdata,  // hit, trans_addr, evicted
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fatlb_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [fatlb_pkg::CFG_DATA_W-1:0]    pwdata,
	input  logic [fatlb_pkg::CFG_DATA_W-1:0]    prdata,
	input  logic                                pready,
	output int                                  mismatches,
	output int                                  outstanding
);
	import fatlb_pkg::*;

	localparam int VPN_W   = VA_W - PAGE_BITS;
	localparam int FRAME_W = PA_W - PAGE_BITS;
	localparam int EXP_DEPTH = 8;
	localparam logic [CFG_ADDR_W-1:0] ADDR_CACHE_ENABLE = {CFG_WORD_CACHE_ENABLE, 2'b00};

	typedef struct packed {
		logic            evicted;
		logic [PA_W-1:0] trans_addr;
		logic            hit;
	} tlb_result_t;

	logic               cache_on;
	logic               ent_valid [ENTRIES];
	logic [VPN_W-1:0]   ent_tag   [ENTRIES];
	logic [FRAME_W-1:0] ent_frame [ENTRIES];
	int                 ent_rank  [ENTRIES];

	tlb_result_t exp_fifo [EXP_DEPTH];
	logic [2:0]  exp_rd;
	logic [2:0]  exp_wr;
	int          exp_count;
	tlb_result_t got_result;
	tlb_result_t want_result;

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (mismatches < 50)
			$display("checker: %s got %h want %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	function automatic int count_valid();
		int n;
		n = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (ent_valid[i])
				n++;
		return n;
	endfunction

	function automatic int find_page(logic [VPN_W-1:0] vpn);
		for (int i = 0; i < ENTRIES; i++)
			if (ent_valid[i] && ent_tag[i] == vpn)
				return i;
		return -1;
	endfunction

	function automatic void promote(int idx);
		int n;
		int r;
		n = count_valid();
		r = ent_rank[idx];
		for (int j = 0; j < ENTRIES; j++)
			if (ent_valid[j] && j != idx && ent_rank[j] > r)
				ent_rank[j]--;
		ent_rank[idx] = n - 1;
	endfunction

	function automatic void drop_oldest();
		int lru;
		int r;
		lru = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (ent_valid[i] && (lru < 0 || ent_rank[i] < ent_rank[lru]))
				lru = i;
		if (lru >= 0) begin
			r = ent_rank[lru];
			for (int j = 0; j < ENTRIES; j++)
				if (ent_valid[j] && ent_rank[j] > r)
					ent_rank[j]--;
			ent_valid[lru] = 1'b0;
			ent_rank[lru] = 0;
		end
	endfunction

	function automatic tlb_result_t predict_translation(logic [ACTION_W-1:0] act,
			logic [VA_W-1:0] va, logic [PA_W-1:0] pa, logic upd);
		tlb_result_t res;
		logic [VPN_W-1:0] vpn;
		int idx;
		int n;
		res = '0;
		vpn = va[VA_W-1:PAGE_BITS];
		case (act)
			ACT_LOOKUP: begin
				if (cache_on) begin
					idx = find_page(vpn);
					if (idx >= 0) begin
						res.hit = 1'b1;
						res.trans_addr = {ent_frame[idx], va[PAGE_BITS-1:0]};
						if (upd)
							promote(idx);
					end
				end
			end
			ACT_REFILL: begin
				if (cache_on) begin
					if (find_page(vpn) >= 0) begin
						res.hit = 1'b1;
					end else begin
						if (count_valid() >= ENTRIES) begin
							drop_oldest();
							res.evicted = 1'b1;
						end
						for (int i = 0; i < ENTRIES; i++) begin
							if (!ent_valid[i]) begin
								n = count_valid();
								ent_valid[i] = 1'b1;
								ent_tag[i] = vpn;
								ent_frame[i] = pa[PA_W-1:PAGE_BITS];
								ent_rank[i] = n;
								break;
							end
						end
					end
				end
			end
			ACT_FLUSH: begin
				for (int i = 0; i < ENTRIES; i++) begin
					ent_valid[i] = 1'b0;
					ent_rank[i] = 0;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_on = 1'b1;
			for (int i = 0; i < ENTRIES; i++) begin
				ent_valid[i] = 1'b0;
				ent_tag[i] = '0;
				ent_frame[i] = '0;
				ent_rank[i] = 0;
			end
			exp_rd = '0;
			exp_wr = '0;
			exp_count = 0;
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_result = m_tdata[$bits(tlb_result_t)-1:0];
				if (exp_count == 0) begin
					report_mismatch("unexpected result beat", 64'(m_tdata), 64'd0);
				end else begin
					want_result = exp_fifo[exp_rd];
					exp_rd = exp_rd + 3'd1;
					exp_count--;
					if (got_result.hit !== want_result.hit)
						report_mismatch("hit", 64'(got_result.hit), 64'(want_result.hit));
					if (got_result.trans_addr !== want_result.trans_addr)
						report_mismatch("trans_addr", 64'(got_result.trans_addr),
							64'(want_result.trans_addr));
					if (got_result.evicted !== want_result.evicted)
						report_mismatch("evicted", 64'(got_result.evicted),
							64'(want_result.evicted));
				end
			end
			if (s_tvalid && s_tready) begin
				if (exp_count == EXP_DEPTH) begin
					report_mismatch("expected results overflow", 64'(exp_count), 64'd0);
				end else begin
					exp_fifo[exp_wr] = predict_translation(s_tuser, s_tdata[VA_W-1:0],
						s_tdata[VA_W+PA_W-1:VA_W], s_tdata[VA_W+PA_W]);
					exp_wr = exp_wr + 3'd1;
					exp_count++;
				end
			end
			if (psel && penable && pready && paddr == ADDR_CACHE_ENABLE) begin
				if (pwrite)
					cache_on = pwdata[0];
				else if (prdata !== CFG_DATA_W'(cache_on))
					report_mismatch("cache_enable read", 64'(prdata), 64'(cache_on));
			end
			outstanding = exp_count;
		end
	end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the fully associative translation cache
// Drives lookups, refills and flushes over a small page pool so that the
// cache fills, hits and evicts, toggles the enable register between phases
// and varies the idling on both sides. The checker does all comparing.
// ----------------------------------------------------------------------------
module tb_top;
	import fatlb_pkg::*;

	localparam int ENTRIES     = 32;
	localparam int PAGE_BITS   = 12;
	localparam int VPN_W       = VA_W - PAGE_BITS;
	localparam int POOL_SIZE   = 40;
	localparam int STALL_LIMIT = 5000;
	localparam logic [ACTION_W-1:0]   ACT_UNUSED        = 2'd3;
	localparam logic [CFG_ADDR_W-1:0] ADDR_CACHE_ENABLE = {CFG_WORD_CACHE_ENABLE, 2'b00};
	localparam logic [VA_W-1:0]       VA_MAX            = '1;
	localparam logic [PA_W-1:0]       PA_MAX            = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // virt_addr, phys_addr, update_recency
	logic [ACTION_W-1:0]   s_tuser;   // action
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;   // hit, trans_addr, evicted
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	int mismatches;
	int outstanding;
	int tx_idle_pct;
	int rx_idle_pct;
	int quiet_cycles;
	logic [VPN_W-1:0] page_pool [POOL_SIZE];

	fully_assoc_tlb_lru_core #(
		.ENTRIES  (ENTRIES),
		.PAGE_BITS(PAGE_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tlb_translation_checker #(
		.ENTRIES  (ENTRIES),
		.PAGE_BITS(PAGE_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	task automatic send_item(logic [ACTION_W-1:0] act, logic [VA_W-1:0] va,
			logic [PA_W-1:0] pa, logic upd);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {3'b000, upd, pa, va};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic apb_access(logic write, logic [CFG_ADDR_W-1:0] addr,
			logic [CFG_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_cache_enable(logic on);
		apb_access(1'b1, ADDR_CACHE_ENABLE, CFG_DATA_W'(on));
		@(posedge clk);
		apb_access(1'b0, ADDR_CACHE_ENABLE, '0);
	endtask

	task automatic send_random(int count);
		logic [ACTION_W-1:0] act;
		logic [VPN_W-1:0]    vpn;
		int                  pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(199);
			if (pick < 90)
				act = ACT_LOOKUP;
			else if (pick < 196)
				act = ACT_REFILL;
			else if (pick < 198)
				act = ACT_FLUSH;
			else
				act = ACT_UNUSED;
			if ($urandom_range(99) < 85)
				vpn = page_pool[$urandom_range(POOL_SIZE-1)];
			else
				vpn = VPN_W'({$urandom, $urandom});
			send_item(act, {vpn, PAGE_BITS'($urandom)}, PA_W'({$urandom, $urandom}),
				1'($urandom_range(1)));
			if ($urandom_range(99) == 0)
				wait_drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_LOOKUP;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		tx_idle_pct = 28;
		rx_idle_pct = 57;
		page_pool[0] = '0;
		page_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			page_pool[i] = VPN_W'({$urandom, $urandom});
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_cache_enable(1'b1);

		send_item(ACT_LOOKUP, '0, '0, 1'b0);
		send_item(ACT_REFILL, '0, '0, 1'b0);
		send_item(ACT_REFILL, VA_MAX, PA_MAX, 1'b0);
		send_item(ACT_LOOKUP, VA_MAX, '0, 1'b1);
		send_item(ACT_LOOKUP, 48'h0000_0000_0FFF, '0, 1'b0);
		send_item(ACT_REFILL, 48'hFFFF_FFFF_F000, 52'h1_2345_6789_A000, 1'b1);
		send_item(ACT_LOOKUP, 48'hFFFF_FFFF_F123, '0, 1'b0);
		send_item(ACT_UNUSED, VA_MAX, PA_MAX, 1'b1);
		send_item(ACT_REFILL, 48'h8000_0000_0000, 52'h8_0000_0000_0000, 1'b0);
		send_item(ACT_LOOKUP, 48'h8000_0000_0ABC, '0, 1'b1);
		send_item(ACT_FLUSH, VA_MAX, PA_MAX, 1'b1);
		send_item(ACT_LOOKUP, '0, '0, 1'b1);
		send_item(ACT_LOOKUP, VA_MAX, '0, 1'b1);
		wait_drain();
		set_cache_enable(1'b0);
		send_item(ACT_REFILL, 48'h0000_0123_4000, 52'h5_5555_5555_5000, 1'b0);
		send_item(ACT_LOOKUP, 48'h0000_0123_4567, '0, 1'b1);
		send_item(ACT_FLUSH, '0, '0, 1'b0);
		wait_drain();
		set_cache_enable(1'b1);
		send_item(ACT_LOOKUP, 48'h0000_0123_4567, '0, 1'b0);
		send_item(ACT_REFILL, 48'h0000_0123_4000, 52'hA_AAAA_AAAA_A000, 1'b0);
		send_item(ACT_LOOKUP, 48'h0000_0123_4567, '0, 1'b1);

		send_random(500);
		wait_drain();
		set_cache_enable(1'b0);
		send_random(60);
		wait_drain();
		set_cache_enable(1'b1);

		tx_idle_pct = 57;
		rx_idle_pct = 28;
		send_random(500);
		wait_drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random(440);
		wait_drain();
		repeat (8) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
